// ===== design/fdss_pkg.sv =====
// Shared types and codes for the FIFO dispatch to service slots block.
`timescale 1ns / 1ps

package fdss_pkg;

    localparam int ID_W     = 16;
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 4;
    localparam int CFG_W    = 5;

    typedef logic [ACTION_W-1:0] t_action;

    localparam t_action ACT_ARRIVE = 2'd0;
    localparam t_action ACT_CALL   = 2'd1;
    localparam t_action ACT_FINISH = 2'd2;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BUSY   = 3'd1,
        ST_QEMPTY = 3'd2,
        ST_BADIDX = 3'd3,
        ST_SEMPTY = 3'd4,
        ST_QFULL  = 3'd5
    } t_status;

endpackage

// ===== design/fdss_req_if.sv =====
// Request channel: action, requester ID and slot index with a valid/ready handshake.
`timescale 1ns / 1ps

interface fdss_req_if
    import fdss_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [ID_W-1:0]      requester_id;
    logic [INDEX_W-1:0]   slot_index;

    modport source (output valid, action, requester_id, slot_index, input ready);
    modport sink   (input valid, action, requester_id, slot_index, output ready);
endinterface

// ===== design/fdss_rsp_if.sv =====
// Result channel: status and released ID with a valid/ready handshake.
`timescale 1ns / 1ps

interface fdss_rsp_if
    import fdss_pkg::*;
();
    logic             valid;
    logic             ready;
    t_status          status;
    logic [ID_W-1:0]  released_id;

    modport source (output valid, status, released_id, input ready);
    modport sink   (input valid, status, released_id, output ready);
endinterface

// ===== design/fifo_dispatch_to_service_slots_core.sv =====
// Top level: FIFO wait queue that dispatches requesters into indexed service slots.
`timescale 1ns / 1ps

// A request is accepted in S_IDLE and finished in S_DONE. In the cycle it is accepted
// the block checks the slot flags and queue count, updates pointers and flags, and issues
// one read, either of the queue head or of the addressed slot. In S_DONE the read data
// is back from the registered memory port, a call writes it into the slot memory, and
// the result is loaded into the output register once that register is free; only then
// does the block return to S_IDLE and take the next request, so it never accepts one
// while another is in flight. The output register lets the block accept a new request
// while a result still waits; a second result then holds until the first is taken.
// Reset clears the queue and all slot flags at once; no clearing pass is needed.

module fifo_dispatch_to_service_slots_core
    import fdss_pkg::*;
#(
    parameter int MAX_SLOTS   = 16,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fdss_req_if.sink          i_req,
    fdss_rsp_if.source        o_rsp,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    localparam int QAW     = $clog2(QUEUE_DEPTH);
    localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CMP_W   = 9;

    localparam logic [QAW-1:0]   Q_LAST      = QAW'(QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0]   Q_FULL      = QCW'(QUEUE_DEPTH);
    localparam logic [CMP_W-1:0] MAX_SLOTS_W = CMP_W'(MAX_SLOTS);

    typedef enum logic {S_IDLE, S_DONE} t_state;

    // Storage.
    logic [ID_W-1:0] mem_queue [QUEUE_DEPTH];
    logic [ID_W-1:0] mem_slot  [MAX_SLOTS];
    logic [ID_W-1:0] r_q_rdata;
    logic [ID_W-1:0] r_s_rdata;

    // Control and pipeline registers.
    t_state               r_state,       n_state;
    logic [CFG_W-1:0]     r_slots_in_use, n_slots_in_use;
    logic [QAW-1:0]       r_head,        n_head;
    logic [QAW-1:0]       r_tail,        n_tail;
    logic [QCW-1:0]       r_count,       n_count;
    logic [MAX_SLOTS-1:0] r_busy,        n_busy;
    t_action              r_act,         n_act;
    logic [SLOT_AW-1:0]   r_sa,          n_sa;
    t_status              r_status,      n_status;
    logic                 r_out_valid,   n_out_valid;
    t_status              r_out_status,  n_out_status;
    logic [ID_W-1:0]      r_out_rel,     n_out_rel;

    logic                 w_fire;
    logic [CMP_W-1:0]     w_cfg_ext;
    logic [CMP_W-1:0]     w_limit;
    logic [CMP_W-1:0]     w_idx_ext;
    logic                 w_idx_ok;
    logic [SLOT_AW-1:0]   w_sa;
    logic                 w_slot_busy;
    t_status              w_status;
    logic                 w_q_we;
    logic                 w_q_re;
    logic                 w_s_re;
    logic                 w_s_we;
    logic                 w_out_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_fire      = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    // Slot count saturates at the number of slots built.
    assign w_cfg_ext   = CMP_W'(r_slots_in_use);
    assign w_limit     = (w_cfg_ext > MAX_SLOTS_W) ? MAX_SLOTS_W : w_cfg_ext;
    assign w_idx_ext   = CMP_W'(i_req.slot_index);
    assign w_idx_ok    = w_idx_ext < w_limit;
    assign w_sa        = w_idx_ext[SLOT_AW-1:0];
    assign w_slot_busy = w_idx_ok && r_busy[w_sa];

    always_comb begin
        w_status = ST_OK;
        unique case (i_req.action)
            ACT_ARRIVE: begin
                if (r_count == Q_FULL) w_status = ST_QFULL;
            end
            ACT_CALL: begin
                priority if (!w_idx_ok)       w_status = ST_BADIDX;
                else if (w_slot_busy)         w_status = ST_BUSY;
                else if (r_count == '0)       w_status = ST_QEMPTY;
                else                          w_status = ST_OK;
            end
            ACT_FINISH: begin
                priority if (!w_idx_ok)       w_status = ST_BADIDX;
                else if (!w_slot_busy)        w_status = ST_SEMPTY;
                else                          w_status = ST_OK;
            end
            default: w_status = ST_OK;
        endcase
    end

    assign w_q_we = w_fire && (i_req.action == ACT_ARRIVE) && (w_status == ST_OK);
    assign w_q_re = w_fire && (i_req.action == ACT_CALL)   && (w_status == ST_OK);
    assign w_s_re = w_fire && (i_req.action == ACT_FINISH) && (w_status == ST_OK);
    // The dequeued ID lands in its slot while the result is formed; repeating the
    // write during an output stall is harmless.
    assign w_s_we = (r_state == S_DONE) && (r_act == ACT_CALL) && (r_status == ST_OK);

    always_comb begin
        n_state        = r_state;
        n_slots_in_use = r_slots_in_use;
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_busy         = r_busy;
        n_act          = r_act;
        n_sa           = r_sa;
        n_status       = r_status;
        n_out_valid    = r_out_valid;
        n_out_status   = r_out_status;
        n_out_rel      = r_out_rel;

        if (i_cfg_we) n_slots_in_use = i_cfg_wdata;

        if (r_out_valid && o_rsp.ready) n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    n_act    = i_req.action;
                    n_sa     = w_sa;
                    n_status = w_status;
                    n_state  = S_DONE;
                    if (w_q_we) begin
                        n_tail  = (r_tail == Q_LAST) ? '0 : r_tail + QAW'(1);
                        n_count = r_count + QCW'(1);
                    end
                    if (w_q_re) begin
                        n_head       = (r_head == Q_LAST) ? '0 : r_head + QAW'(1);
                        n_count      = r_count - QCW'(1);
                        n_busy[w_sa] = 1'b1;
                    end
                    if (w_s_re) n_busy[w_sa] = 1'b0;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_rel    = ((r_act == ACT_FINISH) && (r_status == ST_OK))
                                   ? r_s_rdata : '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_slots_in_use <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_busy         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_slots_in_use <= n_slots_in_use;
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_count        <= n_count;
            r_busy         <= n_busy;
            r_out_valid    <= n_out_valid;
            r_act          <= n_act;
            r_sa           <= n_sa;
            r_status       <= n_status;
            r_out_status   <= n_out_status;
            r_out_rel      <= n_out_rel;
        end
    end

    // Queue memory: one write port at the tail, one registered read port at the head.
    always_ff @(posedge i_clk) begin
        if (w_q_we) mem_queue[r_tail] <= i_req.requester_id;
        if (w_q_re) r_q_rdata <= mem_queue[r_head];
    end

    // Slot memory: written with the dequeued ID, read for a finish.
    always_ff @(posedge i_clk) begin
        if (w_s_we) mem_slot[r_sa] <= r_q_rdata;
        if (w_s_re) r_s_rdata <= mem_slot[w_sa];
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.released_id = r_out_rel;

endmodule

// ===== design/fdss_checker.sv =====
// Port-level checker for the dispatch core and the bind that attaches it.
`timescale 1ns / 1ps

module fdss_checker
    import fdss_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input t_status          i_rsp_status,
    input logic [ID_W-1:0]  i_rsp_released_id
);

    // A released ID is reported only on a successful request.
    a_rel_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != ST_OK)) |-> (i_rsp_released_id == '0))
        else $error("released ID nonzero on a failed request");

    // Only one request is in flight: the cycle after an accept takes no request.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another is in flight");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_released_id)))
        else $error("stalled result changed");

endmodule

bind fifo_dispatch_to_service_slots_core fdss_checker u_fdss_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_released_id (o_rsp.released_id)
);
